// ----- hdl/ghsa_pkg.sv -----
// shared types and constants for the generational handle slot allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ghsa_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int GEN_W      = 8;
  localparam int DATA_W     = 32;

  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int HIDX_W     = 8;
  localparam int HGEN_W     = 8;
  localparam int PAY_W      = 32;

  // stream word layouts, fields packed from bit 0 upward
  localparam int IN_FIELDS_W   = CMD_W + HIDX_W + HGEN_W + PAY_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = STATUS_W + HIDX_W + HGEN_W + PAY_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // one slot memory word
  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [GEN_W-1:0]  gen;
    logic              occupied;
  } slot_entry_t;

  // freed slot plus the generation it will carry when handed out again
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] idx;
  } stack_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    slot_entry_t      data;
  } slot_wr_t;

  typedef struct packed {
    logic         rd_en;
    logic         push;
    logic         pop;
    stack_entry_t push_data;
  } stack_ctl_t;

  typedef struct packed {
    status_t           status;
    logic [HIDX_W-1:0] handle_index;
    logic [HGEN_W-1:0] handle_generation;
    logic [PAY_W-1:0]  payload_out;
  } result_t;

endpackage

// ----- hdl/generational_handle_slot_allocator.sv -----
// result: registered after the execute state; an earlier result that stalls holds it back
// a new command waits until the last one leaves execute: slot memory read, then write-back
// each command: accept issues memory reads; execute checks, writes back, registers result
// a new command is taken while a result waits; it holds in execute until the result drains
// reset: synchronous active-low rst_n empties the pool at once; no clearing pass is needed
`timescale 1ns / 1ps

module generational_handle_slot_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd[1:0], slot_index[9:2], slot_generation[17:10], payload_in[49:18], zero fill
  input  logic [ghsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[1:0], handle_index[9:2], handle_generation[17:10], payload_out[49:18], zero fill
  output logic [ghsa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ghsa_pkg::*;

  // input field unpacking
  logic [CMD_W-1:0]  in_cmd;
  logic [HIDX_W-1:0] in_idx;
  logic [HGEN_W-1:0] in_gen;
  logic [PAY_W-1:0]  in_payload;

  assign in_cmd     = in_tdata[CMD_W-1:0];
  assign in_idx     = in_tdata[CMD_W +: HIDX_W];
  assign in_gen     = in_tdata[CMD_W+HIDX_W +: HGEN_W];
  assign in_payload = in_tdata[CMD_W+HIDX_W+HGEN_W +: PAY_W];

  // links between sequencer and memories
  logic             slot_rd_en;
  logic [IDX_W-1:0] slot_rd_addr;
  slot_entry_t      slot_rd;
  slot_wr_t         slot_wr;
  stack_ctl_t       stack_ctl;
  stack_entry_t     stack_top;
  logic [CNT_W-1:0] stack_depth;
  result_t          result;

  // per-slot payload, generation and occupied flag
  ghsa_slot_mem u_slot_mem (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .wr      (slot_wr),
    .rd_data (slot_rd)
  );

  // freed slots, most recent on top
  ghsa_free_stack u_free_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stack_ctl),
    .top_data (stack_top),
    .depth    (stack_depth)
  );

  // command sequencing, handle checks and output register
  ghsa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_cmd       (in_cmd),
    .in_idx       (in_idx),
    .in_gen       (in_gen),
    .in_payload   (in_payload),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .result       (result),
    .slot_rd_en   (slot_rd_en),
    .slot_rd_addr (slot_rd_addr),
    .slot_rd      (slot_rd),
    .slot_wr      (slot_wr),
    .stack_ctl    (stack_ctl),
    .stack_top    (stack_top),
    .stack_depth  (stack_depth)
  );

  // result packing, fill bits held at zero
  assign out_tdata = OUT_TDATA_W'({result.payload_out, result.handle_generation,
                                   result.handle_index, result.status});

endmodule

// ----- hdl/ghsa_slot_mem.sv -----
// slot memory: payload, generation and occupied flag per slot
// depends on ghsa_pkg; one write port, one registered read port
`timescale 1ns / 1ps

module ghsa_slot_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ghsa_pkg::IDX_W-1:0] rd_addr,
  input  ghsa_pkg::slot_wr_t        wr,
  output ghsa_pkg::slot_entry_t     rd_data
);
  import ghsa_pkg::*;

  slot_entry_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/ghsa_free_stack.sv -----
// lifo of freed slots with its depth counter
// depends on ghsa_pkg; top entry registered on its read enable, ahead of the pop
`timescale 1ns / 1ps

module ghsa_free_stack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ghsa_pkg::stack_ctl_t        ctl,
  output ghsa_pkg::stack_entry_t      top_data,
  output logic [ghsa_pkg::CNT_W-1:0]  depth
);
  import ghsa_pkg::*;

  stack_entry_t     mem [SLOT_COUNT];
  logic [CNT_W-1:0] depth_r;
  logic [CNT_W-1:0] depth_nxt;
  logic [CNT_W-1:0] top_ptr;

  assign top_ptr = depth_r - CNT_W'(1);
  assign depth   = depth_r;

  always_comb begin
    depth_nxt = depth_r;
    if (ctl.push) begin
      depth_nxt = depth_r + CNT_W'(1);
    end else if (ctl.pop) begin
      depth_nxt = depth_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[depth_r[IDX_W-1:0]] <= ctl.push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      top_data <= mem[top_ptr[IDX_W-1:0]];
    end
  end

endmodule

// ----- hdl/ghsa_ctrl.sv -----
// command sequencer: handle check, slot allocation and result register
// depends on ghsa_pkg; drives the slot memory and the free stack
`timescale 1ns / 1ps

module ghsa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ghsa_pkg::CMD_W-1:0]   in_cmd,
  input  logic [ghsa_pkg::HIDX_W-1:0]  in_idx,
  input  logic [ghsa_pkg::HGEN_W-1:0]  in_gen,
  input  logic [ghsa_pkg::PAY_W-1:0]   in_payload,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ghsa_pkg::result_t            result,
  output logic                         slot_rd_en,
  output logic [ghsa_pkg::IDX_W-1:0]   slot_rd_addr,
  input  ghsa_pkg::slot_entry_t        slot_rd,
  output ghsa_pkg::slot_wr_t           slot_wr,
  output ghsa_pkg::stack_ctl_t         stack_ctl,
  input  ghsa_pkg::stack_entry_t       stack_top,
  input  logic [ghsa_pkg::CNT_W-1:0]   stack_depth
);
  import ghsa_pkg::*;

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [GEN_W-1:0]  gen_r;
  logic [DATA_W-1:0] pay_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           result_r, result_nxt;
  logic              accept;
  logic              fire;
  logic              handle_ok;
  logic [GEN_W-1:0]  gen_inc;

  // fsm transitions
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
    accept   = in_ready && in_valid;
    fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  end

  assign slot_rd_en   = accept;
  assign slot_rd_addr = in_idx[IDX_W-1:0];

  assign handle_ok = ({1'b0, idx_r} < used_r) && (slot_rd.gen == gen_r) &&
                     slot_rd.occupied;
  assign gen_inc   = slot_rd.gen + GEN_W'(1);

  always_comb begin
    result_nxt         = result_r;
    used_nxt           = used_r;
    slot_wr            = '0;
    stack_ctl          = '0;
    stack_ctl.rd_en    = accept;
    if (fire) begin
      result_nxt        = '0;
      result_nxt.status = ST_INVALID;
      case (cmd_r)
        CMD_INSERT: begin
          if (stack_depth != '0) begin
            stack_ctl.pop                = 1'b1;
            slot_wr.we                   = 1'b1;
            slot_wr.addr                 = stack_top.idx;
            slot_wr.data.gen             = stack_top.gen;
            result_nxt.status            = ST_OK;
            result_nxt.handle_index      = HIDX_W'(stack_top.idx);
            result_nxt.handle_generation = HGEN_W'(stack_top.gen);
          end else if (used_r < CNT_W'(SLOT_COUNT)) begin
            // never-used slot starts at generation zero
            used_nxt                     = used_r + CNT_W'(1);
            slot_wr.we                   = 1'b1;
            slot_wr.addr                 = used_r[IDX_W-1:0];
            slot_wr.data.gen             = '0;
            result_nxt.status            = ST_OK;
            result_nxt.handle_index      = HIDX_W'(used_r[IDX_W-1:0]);
          end else begin
            result_nxt.status = ST_FULL;
          end
          slot_wr.data.payload  = pay_r;
          slot_wr.data.occupied = 1'b1;
        end
        CMD_REMOVE: begin
          if (handle_ok && stack_depth < CNT_W'(SLOT_COUNT)) begin
            slot_wr.we            = 1'b1;
            slot_wr.addr          = idx_r;
            slot_wr.data.payload  = slot_rd.payload;
            slot_wr.data.gen      = gen_inc;
            slot_wr.data.occupied = 1'b0;
            stack_ctl.push        = 1'b1;
            stack_ctl.push_data   = '{gen: gen_inc, idx: idx_r};
            result_nxt.status     = ST_OK;
          end
        end
        CMD_READ: begin
          if (handle_ok) begin
            result_nxt.status      = ST_OK;
            result_nxt.payload_out = PAY_W'(slot_rd.payload);
          end
        end
        default: result_nxt.status = ST_INVALID;
      endcase
    end
  end

  assign out_valid_nxt = fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    if (accept) begin
      cmd_r <= in_cmd;
      idx_r <= in_idx[IDX_W-1:0];
      gen_r <= GEN_W'(in_gen);
      pay_r <= DATA_W'(in_payload);
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ----- hdl/ghsa_checker.sv -----
// port-level checks for the slot allocator
// depends on ghsa_pkg; bound to the top level below
`timescale 1ns / 1ps

module ghsa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ghsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ghsa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ghsa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one command in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a command is in flight");

  // every accepted command shows a result once execute and the output register have passed
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("result missing after accepted command");

  // status code is one of ok, invalid, full
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[STATUS_W-1:0] == ST_OK) ||
                   (out_tdata[STATUS_W-1:0] == ST_INVALID) ||
                   (out_tdata[STATUS_W-1:0] == ST_FULL))
    else $error("unused status code");

  // a failed command returns zero in every other field
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STATUS_W-1:0] != ST_OK) |->
      out_tdata[OUT_TDATA_W-1:STATUS_W] == '0)
    else $error("failed command carries nonzero fields");

endmodule

bind generational_handle_slot_allocator ghsa_checker u_ghsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/tb_generational_handle_slot_allocator.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the generational handle slot allocator
// depends on ghsa_pkg and generational_handle_slot_allocator from hdl

module tb_generational_handle_slot_allocator;
  import ghsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // field offsets in the stream words, packed from bit 0 up
  localparam int CMD_LSB = 0;
  localparam int IDX_LSB = CMD_LSB + CMD_W;
  localparam int GEN_LSB = IDX_LSB + HIDX_W;
  localparam int PIN_LSB = GEN_LSB + HGEN_W;
  localparam int ST_LSB  = 0;
  localparam int HIX_LSB = ST_LSB + STATUS_W;
  localparam int HGN_LSB = HIX_LSB + HIDX_W;
  localparam int POT_LSB = HGN_LSB + HGEN_W;

  // the one command code the block has no operation for
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // tracks pool contents and the results each accepted command must produce
  class slot_pool_scoreboard;
    logic [GEN_W-1:0]  gen_tbl[SLOT_COUNT];
    logic [DATA_W-1:0] payload_tbl[SLOT_COUNT];
    bit                occupied[SLOT_COUNT];
    logic [IDX_W-1:0]  free_slots[$];
    int unsigned       slots_issued;
    result_t           expected_results[$];
    int unsigned       mismatches;

    function new();
      foreach (gen_tbl[i]) begin
        gen_tbl[i]     = '0;
        payload_tbl[i] = '0;
        occupied[i]    = 1'b0;
      end
      slots_issued = 0;
      mismatches   = 0;
    endfunction

    function bit handle_live(input logic [HIDX_W-1:0] idx, input logic [HGEN_W-1:0] gen);
      return (idx < slots_issued) && (gen_tbl[idx] == gen) && occupied[idx];
    endfunction

    function bit pool_full();
      return (free_slots.size() == 0) && (slots_issued == SLOT_COUNT);
    endfunction

    // picks a random handle that is currently valid
    function bit pick_live(output logic [HIDX_W-1:0] idx, output logic [HGEN_W-1:0] gen);
      logic [IDX_W-1:0] live[$];
      int k;
      for (int i = 0; i < SLOT_COUNT; i++)
        if (occupied[i]) live.push_back(IDX_W'(i));
      idx = '0;
      gen = '0;
      if (live.size() == 0) return 1'b0;
      k   = $urandom_range(live.size() - 1);
      idx = live[k];
      gen = gen_tbl[live[k]];
      return 1'b1;
    endfunction

    // applies one accepted command to the pool and queues its result
    function void apply_cmd(input logic [IN_TDATA_W-1:0] word);
      logic [CMD_W-1:0]  op;
      logic [HIDX_W-1:0] idx;
      logic [HGEN_W-1:0] gen;
      logic [PAY_W-1:0]  data;
      logic [IDX_W-1:0]  slot;
      bit                have;
      result_t           r;
      op   = word[CMD_LSB +: CMD_W];
      idx  = word[IDX_LSB +: HIDX_W];
      gen  = word[GEN_LSB +: HGEN_W];
      data = word[PIN_LSB +: PAY_W];
      have = 1'b0;
      slot = '0;
      r.status            = ST_INVALID;
      r.handle_index      = '0;
      r.handle_generation = '0;
      r.payload_out       = '0;
      case (op)
        CMD_INSERT: begin
          // most recently freed slot first, else the next fresh one
          if (free_slots.size() > 0) begin
            slot = free_slots.pop_back();
            have = 1'b1;
          end else if (slots_issued < SLOT_COUNT) begin
            slot = IDX_W'(slots_issued);
            slots_issued++;
            have = 1'b1;
          end
          if (have) begin
            payload_tbl[slot]   = data;
            occupied[slot]      = 1'b1;
            r.status            = ST_OK;
            r.handle_index      = slot;
            r.handle_generation = gen_tbl[slot];
          end else begin
            r.status = ST_FULL;
          end
        end
        CMD_REMOVE: begin
          if (handle_live(idx, gen) && free_slots.size() < SLOT_COUNT) begin
            occupied[idx] = 1'b0;
            gen_tbl[idx]  = gen_tbl[idx] + 1'b1;
            free_slots.push_back(idx);
            r.status = ST_OK;
          end
        end
        CMD_READ: begin
          if (handle_live(idx, gen)) begin
            r.status      = ST_OK;
            r.payload_out = payload_tbl[idx];
          end
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(input logic [OUT_TDATA_W-1:0] word);
      result_t got;
      result_t want;
      got.status            = status_t'(word[ST_LSB +: STATUS_W]);
      got.handle_index      = word[HIX_LSB +: HIDX_W];
      got.handle_generation = word[HGN_LSB +: HGEN_W];
      got.payload_out       = word[POT_LSB +: PAY_W];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing pending: st=%0d idx=%0d gen=%0d pay=%h",
                   $realtime, got.status, got.handle_index, got.handle_generation,
                   got.payload_out);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.handle_index !== want.handle_index ||
            got.handle_generation !== want.handle_generation ||
            got.payload_out !== want.payload_out) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: exp st=%0d idx=%0d gen=%0d pay=%h got st=%0d idx=%0d gen=%0d pay=%h",
                     $realtime,
                     want.status, want.handle_index, want.handle_generation, want.payload_out,
                     got.status, got.handle_index, got.handle_generation, got.payload_out);
        end
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  slot_pool_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  generational_handle_slot_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // result side: random back-pressure, checking and the stall watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one command transfer, with random idle cycles ahead of it
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [HIDX_W-1:0] idx,
                          input logic [HGEN_W-1:0] gen, input logic [PAY_W-1:0] data);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[CMD_LSB +: CMD_W]  = op;
    word[IDX_LSB +: HIDX_W] = idx;
    word[GEN_LSB +: HGEN_W] = gen;
    word[PIN_LSB +: PAY_W]  = data;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_cmd(word);
  endtask

  // insert with random noise in the unused handle fields
  task automatic send_rand_insert();
    send_cmd(CMD_INSERT, HIDX_W'($urandom_range(255)), HGEN_W'($urandom_range(255)),
             $urandom);
  endtask

  // random mix: mostly valid handles, with stale, unknown and unused-code requests
  task automatic send_mix(input int count);
    logic [HIDX_W-1:0] idx;
    logic [HGEN_W-1:0] gen;
    logic [PAY_W-1:0]  data;
    logic [CMD_W-1:0]  op;
    int                pick;
    repeat (count) begin
      pick = $urandom_range(99);
      idx  = HIDX_W'($urandom_range(255));
      gen  = HGEN_W'($urandom_range(255));
      data = $urandom;
      if (pick < 35) begin
        if ($urandom_range(7) == 0) data = $urandom_range(1) ? '1 : '0;
        send_cmd(CMD_INSERT, idx, gen, data);
      end else if (pick < 50) begin
        if (sb.pick_live(idx, gen)) send_cmd(CMD_REMOVE, idx, gen, data);
        else send_cmd(CMD_INSERT, idx, gen, data);
      end else if (pick < 75) begin
        void'(sb.pick_live(idx, gen));
        send_cmd(CMD_READ, idx, gen, data);
      end else if (pick < 85) begin
        // right slot, wrong generation
        void'(sb.pick_live(idx, gen));
        gen = gen ^ (8'd1 << $urandom_range(7));
        op  = $urandom_range(1) ? CMD_REMOVE : CMD_READ;
        send_cmd(op, idx, gen, data);
      end else if (pick < 95) begin
        op = $urandom_range(1) ? CMD_REMOVE : CMD_READ;
        send_cmd(op, idx, gen, data);
      end else begin
        send_cmd(CMD_UNUSED, idx, gen, data);
      end
    end
  endtask

  initial begin
    logic [HIDX_W-1:0] idx;
    logic [HGEN_W-1:0] gen;
    logic [HGEN_W-1:0] old_gen;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no idling: directed corner cases first
    send_idle_pct = 0;
    stall_pct     = 0;
    send_cmd(CMD_READ,   8'd0,   8'd0,   32'h0000_0000);  // empty pool, never used index
    send_cmd(CMD_REMOVE, 8'd0,   8'd0,   32'h0000_0000);
    send_cmd(CMD_INSERT, 8'd0,   8'd0,   32'h0000_0000);  // fresh slot 0
    send_cmd(CMD_INSERT, 8'hFF,  8'hFF,  32'hFFFF_FFFF);  // fresh slot 1, noise in handle
    send_cmd(CMD_READ,   8'd0,   8'd0,   32'hFFFF_FFFF);
    send_cmd(CMD_READ,   8'd1,   8'd0,   32'h0000_0000);
    send_cmd(CMD_READ,   8'd1,   8'hFF,  32'h0000_0000);  // wrong generation
    send_cmd(CMD_READ,   8'hFF,  8'd0,   32'h0000_0000);  // index beyond slots issued
    send_cmd(CMD_UNUSED, 8'hFF,  8'hFF,  32'hFFFF_FFFF);
    send_cmd(CMD_REMOVE, 8'd0,   8'd0,   32'h0000_0000);
    send_cmd(CMD_READ,   8'd0,   8'd0,   32'h0000_0000);  // stale after remove
    send_cmd(CMD_REMOVE, 8'd0,   8'd0,   32'h0000_0000);  // double remove
    send_cmd(CMD_REMOVE, 8'd1,   8'd0,   32'h0000_0000);
    send_cmd(CMD_INSERT, 8'd0,   8'd0,   32'hA5A5_A5A5);  // reuse slot 1, last freed
    send_cmd(CMD_INSERT, 8'd0,   8'd0,   32'h5A5A_5A5A);  // then slot 0
    send_cmd(CMD_INSERT, 8'd0,   8'd0,   32'h1234_5678);  // stack empty, fresh slot 2
    send_cmd(CMD_READ,   8'd1,   8'd1,   32'h0000_0000);
    send_cmd(CMD_READ,   8'd0,   8'd0,   32'h0000_0000);  // old generation
    send_cmd(CMD_READ,   8'd2,   8'd0,   32'h0000_0000);
    send_cmd(CMD_UNUSED, 8'd0,   8'd0,   32'h0000_0000);
    send_mix(60);

    send_idle_pct = 58;
    send_mix(60);

    // receiver stalls: run the pool dry, then poke at the full pool
    send_idle_pct = 0;
    stall_pct     = 58;
    while (!sb.pool_full()) send_rand_insert();
    repeat (3) send_rand_insert();
    send_cmd(CMD_READ, 8'hFF, sb.gen_tbl[SLOT_COUNT-1], $urandom);
    send_cmd(CMD_REMOVE, 8'hFF, sb.gen_tbl[SLOT_COUNT-1], $urandom);
    send_rand_insert();
    send_mix(30);

    // both sides idle: churn one slot through remove and reinsert
    send_idle_pct = 35;
    stall_pct     = 35;
    if (!sb.pick_live(idx, gen)) begin
      send_cmd(CMD_INSERT, 8'd0, 8'd0, $urandom);
      void'(sb.pick_live(idx, gen));
    end
    for (int n = 0; n < 32; n++) begin
      old_gen = sb.gen_tbl[idx];
      send_cmd(CMD_REMOVE, idx, old_gen, $urandom);
      send_rand_insert();
      // the freed slot sits on top of the stack, so the insert hands it back
      if (n % 8 == 0 || sb.gen_tbl[idx] == '0) begin
        send_cmd(CMD_READ, idx, old_gen, $urandom);
        send_cmd(CMD_READ, idx, sb.gen_tbl[idx], $urandom);
      end
    end
    send_mix(30);

    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ghsa_pkg.sv
hdl/ghsa_slot_mem.sv
hdl/ghsa_free_stack.sv
hdl/ghsa_ctrl.sv
hdl/generational_handle_slot_allocator.sv
hdl/ghsa_checker.sv
sim/tb_generational_handle_slot_allocator.sv
